>>> hdl/kcalc_pkg.sv
// kcalc_pkg: shared types and constants for the keypad calculator
`timescale 1ns / 1ps
package kcalc_pkg;

  // key codes
  localparam logic [7:0] KEY_ON    = 8'h41;
  localparam logic [7:0] KEY_DOT   = 8'h2E;
  localparam logic [7:0] KEY_EQ    = 8'h3D;
  localparam logic [7:0] KEY_ADD   = 8'h2B;
  localparam logic [7:0] KEY_SUB   = 8'h2D;
  localparam logic [7:0] KEY_MUL   = 8'h2A;
  localparam logic [7:0] KEY_DIV   = 8'h2F;
  localparam logic [7:0] KEY_ZERO  = 8'h30;
  localparam logic [7:0] KEY_NINE  = 8'h39;

  localparam logic [7:0] IDLE_LIMIT_RST = 8'd50;
  localparam logic [7:0] IDLE_SAT       = 8'd255;

  // reciprocal of ten, exact for 32-bit dividends after a shift of 35
  localparam logic [31:0] RECIP_TEN = 32'hCCCCCCCD;
  localparam int          RECIP_SHIFT = 35;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_ON     = 3'd1,
    EV_CLEAR  = 3'd2,
    EV_ECHO   = 3'd3,
    EV_RESULT = 3'd4,
    EV_OFF    = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RUN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic finish;
  } kcalc_cmd_t;

  typedef struct packed {
    logic need_iter;
    logic iter_done;
  } kcalc_sts_t;

endpackage

>>> hdl/kcalc_iter.sv
// kcalc_iter: shared iterative unit, shift-add multiply and restoring divide
`timescale 1ns / 1ps
module kcalc_iter
  import kcalc_pkg::*;
#(
  parameter int FRAC_BITS   = 16,
  parameter int VALUE_WIDTH = 48
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   is_div,
  input  logic [VALUE_WIDTH-1:0] a_mag,
  input  logic [VALUE_WIDTH-1:0] b_mag,
  output logic                   done,
  output logic                   big,
  output logic [VALUE_WIDTH-1:0] mag
);

  localparam int W      = VALUE_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int NQ     = W + F;
  localparam int CNT_W  = $clog2(NQ + 1);

  logic             busy_r, busy_nxt;
  logic             div_r, div_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [2*W-1:0]   p_r, p_nxt;
  logic [W-1:0]     a_r, a_nxt;
  logic [W-1:0]     b_r, b_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [NQ-1:0]    nq_r, nq_nxt;
  logic [CNT_W-1:0] last;
  logic [W:0]       mul_sum;
  logic [W:0]       rem_sh;
  logic             ge;

  assign last = div_r ? CNT_W'(NQ - 1) : CNT_W'(W - 1);
  assign done = busy_r && (cnt_r == last);

  // one multiply or divide step per cycle
  always_comb begin
    busy_nxt = busy_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    p_nxt    = p_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    rem_nxt  = rem_r;
    nq_nxt   = nq_r;
    mul_sum  = {1'b0, p_r[2*W-1:W]} + (p_r[0] ? {1'b0, a_r} : {(W+1){1'b0}});
    rem_sh   = {rem_r, nq_r[NQ-1]};
    ge       = rem_sh >= {1'b0, b_r};
    if (start) begin
      busy_nxt = 1'b1;
      div_nxt  = is_div;
      cnt_nxt  = '0;
      a_nxt    = a_mag;
      b_nxt    = b_mag;
      p_nxt    = {{W{1'b0}}, b_mag};
      rem_nxt  = '0;
      nq_nxt   = {a_mag, {F{1'b0}}};
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (done) begin
        busy_nxt = 1'b0;
      end
      if (div_r) begin
        rem_nxt = ge ? W'(rem_sh - {1'b0, b_r}) : rem_sh[W-1:0];
        nq_nxt  = {nq_r[NQ-2:0], ge};
      end else begin
        p_nxt = {mul_sum, p_r[W-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    div_r <= div_nxt;
    p_r   <= p_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    rem_r <= rem_nxt;
    nq_r  <= nq_nxt;
  end

  // magnitude of the scaled result and whether it exceeds the word
  always_comb begin
    if (div_r) begin
      big = |nq_r[NQ-1:W];
      mag = nq_r[W-1:0];
    end else begin
      big = |p_r[2*W-1:W+F];
      mag = p_r[W+F-1:F];
    end
  end

endmodule

>>> hdl/kcalc_dp.sv
// kcalc_dp: calculator state, key decode, arithmetic and result register
`timescale 1ns / 1ps
module kcalc_dp
  import kcalc_pkg::*;
#(
  parameter int FRAC_BITS   = 16,
  parameter int VALUE_WIDTH = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  kcalc_cmd_t                    cmd,
  output kcalc_sts_t                    sts,
  input  logic                          key_present,
  input  logic [7:0]                    key_code,
  input  logic                          cfg_we,
  input  logic [7:0]                    cfg_wdata,
  output logic [2:0]                    display_event,
  output logic [7:0]                    echo_key,
  output logic signed [VALUE_WIDTH-1:0] result_value,
  output logic                          divide_by_zero,
  output logic                          overflow
);

  localparam int W  = VALUE_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int WW = F + 1;
  localparam int WEIGHT_INIT = ((1 << F) + 5) / 10;
  localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  // architectural state
  logic          on_r, on_nxt;
  logic [W-1:0]  entry_r, entry_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  op_t           pend_r, pend_nxt;
  logic          frac_r, frac_nxt;
  logic [WW-1:0] weight_r, weight_nxt;
  logic [7:0]    idle_r, idle_nxt;
  logic [7:0]    limit_r;
  logic          present_r;
  logic [7:0]    key_r;

  // result register
  event_t        ev_nxt;
  logic [2:0]    ev_out_r;
  logic [7:0]    echo_nxt, echo_out_r;
  logic [W-1:0]  res_nxt, res_out_r;
  logic          dz_nxt, dz_out_r;
  logic          ovf_nxt, ovf_out_r;

  // decode and arithmetic
  logic          is_digit, is_dot, is_op, is_eq;
  logic [3:0]    digit_val;
  op_t           key_op;
  logic [W-1:0]  a_mag, b_mag;
  logic          neg;
  logic          it_done, it_big;
  logic [W-1:0]  it_mag;
  logic [W-1:0]  fm_val;
  logic          fm_ovf;
  logic [W:0]    add_s, sub_s, frac_s;
  logic [W-1:0]  op_val;
  logic          op_ovf, op_dz;
  logic [WW+3:0] fd_prod;
  logic [W-1:0]  frac_add;
  logic [WW+31:0] w_prod;
  logic [WW-1:0] w_div;
  logic [W+4:0]  e_ext, int_t, dig_sh;
  logic          on_mid;
  logic [7:0]    idle_base;

  // key classes
  always_comb begin
    is_digit  = (key_r >= KEY_ZERO) && (key_r <= KEY_NINE);
    is_dot    = key_r == KEY_DOT;
    is_op     = (key_r == KEY_ADD) || (key_r == KEY_SUB) ||
                (key_r == KEY_MUL) || (key_r == KEY_DIV);
    is_eq     = key_r == KEY_EQ;
    digit_val = key_r[3:0];
    case (key_r)
      KEY_ADD: key_op = OP_ADD;
      KEY_SUB: key_op = OP_SUB;
      KEY_MUL: key_op = OP_MUL;
      default: key_op = OP_DIV;
    endcase
  end

  assign sts.need_iter = present_r && on_r && (key_r != KEY_ON) && (is_op || is_eq) &&
                         ((pend_r == OP_MUL) || ((pend_r == OP_DIV) && (entry_r != '0)));
  assign sts.iter_done = it_done;

  // operand magnitudes for the shared unit
  assign a_mag = acc_r[W-1] ? W'(~acc_r + 1'b1) : acc_r;
  assign b_mag = entry_r[W-1] ? W'(~entry_r + 1'b1) : entry_r;
  assign neg   = acc_r[W-1] ^ entry_r[W-1];

  kcalc_iter #(
    .FRAC_BITS   (FRAC_BITS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_iter (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.start),
    .is_div (pend_r == OP_DIV),
    .a_mag  (a_mag),
    .b_mag  (b_mag),
    .done   (it_done),
    .big    (it_big),
    .mag    (it_mag)
  );

  // signed value from magnitude, saturating
  always_comb begin
    if (neg) begin
      fm_ovf = it_big || (it_mag > VMIN);
      fm_val = fm_ovf ? VMIN : W'(~it_mag + 1'b1);
    end else begin
      fm_ovf = it_big || it_mag[W-1];
      fm_val = fm_ovf ? VMAX : it_mag;
    end
  end

  // pending operation applied to accumulator and entry
  always_comb begin
    add_s  = {acc_r[W-1], acc_r} + {entry_r[W-1], entry_r};
    sub_s  = {acc_r[W-1], acc_r} - {entry_r[W-1], entry_r};
    op_val = entry_r;
    op_ovf = 1'b0;
    op_dz  = 1'b0;
    case (pend_r)
      OP_ADD: begin
        op_ovf = add_s[W] != add_s[W-1];
        op_val = op_ovf ? (add_s[W] ? VMIN : VMAX) : add_s[W-1:0];
      end
      OP_SUB: begin
        op_ovf = sub_s[W] != sub_s[W-1];
        op_val = op_ovf ? (sub_s[W] ? VMIN : VMAX) : sub_s[W-1:0];
      end
      OP_MUL: begin
        op_ovf = fm_ovf;
        op_val = fm_val;
      end
      OP_DIV: begin
        if (entry_r == '0) begin
          op_dz  = 1'b1;
          op_val = acc_r[W-1] ? VMIN : VMAX;
        end else begin
          op_ovf = fm_ovf;
          op_val = fm_val;
        end
      end
      default: begin
        op_val = entry_r;
      end
    endcase
  end

  // digit entry arithmetic
  always_comb begin
    fd_prod  = digit_val * weight_r;
    frac_add = W'(fd_prod);
    frac_s   = {entry_r[W-1], entry_r} + {1'b0, frac_add};
    w_prod   = weight_r * RECIP_TEN;
    w_div    = WW'(w_prod >> RECIP_SHIFT);
    e_ext    = {{5{entry_r[W-1]}}, entry_r};
    dig_sh   = {{(W+1){1'b0}}, digit_val} << F;
    int_t    = (e_ext << 3) + (e_ext << 1) + dig_sh;
  end

  // tick commit
  always_comb begin
    on_nxt     = on_r;
    entry_nxt  = entry_r;
    acc_nxt    = acc_r;
    pend_nxt   = pend_r;
    frac_nxt   = frac_r;
    weight_nxt = weight_r;
    ev_nxt     = EV_NONE;
    echo_nxt   = '0;
    res_nxt    = '0;
    dz_nxt     = 1'b0;
    ovf_nxt    = 1'b0;
    idle_base  = idle_r;
    if (present_r) begin
      if (key_r == KEY_ON) begin
        if (!on_r) begin
          on_nxt = 1'b1;
          ev_nxt = EV_ON;
        end else begin
          entry_nxt  = '0;
          acc_nxt    = '0;
          pend_nxt   = OP_NONE;
          frac_nxt   = 1'b0;
          weight_nxt = WW'(WEIGHT_INIT);
          ev_nxt     = EV_CLEAR;
        end
        idle_base = '0;
      end else if (on_r) begin
        if (is_digit) begin
          if (frac_r) begin
            ovf_nxt    = frac_s[W] != frac_s[W-1];
            entry_nxt  = ovf_nxt ? VMAX : frac_s[W-1:0];
            weight_nxt = w_div;
          end else if ($signed(int_t) > $signed({5'b0, VMAX})) begin
            ovf_nxt   = 1'b1;
            entry_nxt = VMAX;
          end else begin
            entry_nxt = int_t[W-1:0];
          end
          ev_nxt    = EV_ECHO;
          echo_nxt  = key_r;
          idle_base = '0;
        end else if (is_dot) begin
          frac_nxt  = 1'b1;
          ev_nxt    = EV_ECHO;
          echo_nxt  = key_r;
          idle_base = '0;
        end else if (is_op) begin
          acc_nxt    = op_val;
          ovf_nxt    = op_ovf;
          dz_nxt     = op_dz;
          pend_nxt   = key_op;
          entry_nxt  = '0;
          frac_nxt   = 1'b0;
          weight_nxt = WW'(WEIGHT_INIT);
          ev_nxt     = EV_ECHO;
          echo_nxt   = key_r;
          idle_base  = '0;
        end else if (is_eq) begin
          res_nxt    = op_val;
          ovf_nxt    = op_ovf;
          dz_nxt     = op_dz;
          entry_nxt  = '0;
          acc_nxt    = '0;
          pend_nxt   = OP_NONE;
          frac_nxt   = 1'b0;
          weight_nxt = WW'(WEIGHT_INIT);
          ev_nxt     = EV_RESULT;
          idle_base  = '0;
        end
      end
    end
    idle_nxt = (idle_base < IDLE_SAT) ? idle_base + 8'd1 : idle_base;
    on_mid   = on_nxt;
    if (on_mid && (idle_nxt >= limit_r)) begin
      on_nxt   = 1'b0;
      ev_nxt   = EV_OFF;
      echo_nxt = '0;
    end
  end

  // state and input capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_r     <= 1'b0;
      entry_r  <= '0;
      acc_r    <= '0;
      pend_r   <= OP_NONE;
      frac_r   <= 1'b0;
      weight_r <= WW'(WEIGHT_INIT);
      idle_r   <= '0;
      limit_r  <= IDLE_LIMIT_RST;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (cmd.finish) begin
        on_r     <= on_nxt;
        entry_r  <= entry_nxt;
        acc_r    <= acc_nxt;
        pend_r   <= pend_nxt;
        frac_r   <= frac_nxt;
        weight_r <= weight_nxt;
        idle_r   <= idle_nxt;
      end
    end
    if (cmd.load) begin
      present_r <= key_present;
      key_r     <= key_code;
    end
    if (cmd.finish) begin
      ev_out_r   <= ev_nxt;
      echo_out_r <= echo_nxt;
      res_out_r  <= res_nxt;
      dz_out_r   <= dz_nxt;
      ovf_out_r  <= ovf_nxt;
    end
  end

  assign display_event  = ev_out_r;
  assign echo_key       = echo_out_r;
  assign result_value   = res_out_r;
  assign divide_by_zero = dz_out_r;
  assign overflow       = ovf_out_r;

endmodule

>>> hdl/kcalc_ctrl.sv
// kcalc_ctrl: sequencing state machine and output handshake
`timescale 1ns / 1ps
module kcalc_ctrl
  import kcalc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  kcalc_sts_t sts,
  output kcalc_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_busy;

  assign out_busy = out_valid_r && out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = sts.need_iter ? ST_RUN : ST_FINISH;
      end
      ST_RUN: begin
        if (sts.iter_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_DECODE: begin
        cmd.start = sts.need_iter;
      end
      ST_FINISH: begin
        cmd.finish = !out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // result item handshake
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> hdl/keypad_four_function_calculator.sv
// keypad_four_function_calculator: top level of the keypad calculator
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  key_present, key_code
//   out_     output     out_valid/out_stall  display_event, echo_key, result_value, flags
//   cfg_     input      cfg_we               cfg_wdata (idle limit)
//
// a plain key passes from accept through the decode and finish states, and its result is
// registered on leaving finish; the next key is accepted only back in idle; an operator or
// = key with a pending multiply, or a pending divide by a nonzero entry, also waits in the
// run state between decode and finish for the one-bit-per-cycle shared multiply/divide unit
// synchronous active-low reset; no clearing pass, items accepted straight away
// a result waits in the output register under out_stall while the next item is taken;
// that next item then holds in its last cycle until the waiting result is taken
`timescale 1ns / 1ps
module keypad_four_function_calculator
  import kcalc_pkg::*;
#(
  parameter int FRAC_BITS   = 16,
  parameter int VALUE_WIDTH = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_key_present,
  input  logic [7:0]                    in_key_code,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_display_event,
  output logic [7:0]                    out_echo_key,
  output logic signed [VALUE_WIDTH-1:0] out_result_value,
  output logic                          out_divide_by_zero,
  output logic                          out_overflow,
  input  logic                          cfg_we,
  input  logic [7:0]                    cfg_wdata
);

  kcalc_cmd_t cmd;
  kcalc_sts_t sts;

  // controller
  kcalc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  kcalc_dp #(
    .FRAC_BITS   (FRAC_BITS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .key_present    (in_key_present),
    .key_code       (in_key_code),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .display_event  (out_display_event),
    .echo_key       (out_echo_key),
    .result_value   (out_result_value),
    .divide_by_zero (out_divide_by_zero),
    .overflow       (out_overflow)
  );

endmodule
